FILE: rtl/ssdm_pkg.sv
// ----------------------------------------------------------------------------
// ssdm_pkg
// Beat types and codes shared by the suffix dictionary matcher.
// ----------------------------------------------------------------------------
package ssdm_pkg;

  localparam int LETTER_W = 5;

  // request kinds
  localparam logic [1:0] REQ_PATTERN = 2'd0;
  localparam logic [1:0] REQ_END     = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [LETTER_W-1:0] letter;
  } req_t;

  typedef struct packed {
    logic       match;
    logic [1:0] status;
  } rsp_t;

endpackage

FILE: rtl/ssdm_node_mem.sv
// ----------------------------------------------------------------------------
// ssdm_node_mem
// Trie node table: one write port, one registered read port, and a
// clearing sweep after reset that zeroes every entry, one a cycle.
// ----------------------------------------------------------------------------
module ssdm_node_mem #(
  parameter int DEPTH = 6656,
  parameter int DW    = 9
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  output logic                     clearing
);

  localparam int AW = $clog2(DEPTH);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] clear_addr;

  // clearing sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // storage, sweep takes the write port while it runs
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/stream_suffix_dictionary_matcher.sv
// ----------------------------------------------------------------------------
// stream_suffix_dictionary_matcher
// Reversed-trie dictionary with a letter stream checked for pattern suffixes.
// ----------------------------------------------------------------------------
// Patterns are loaded one letter per beat, last letter first, and closed by an
// end beat; query beats push a letter into a history ring and report whether
// any stored pattern is a suffix of the stream. Every request beat yields one
// response beat. After reset the node table is swept clear of all its
// NODE_COUNT*ALPHABET_SIZE entries with req_ready low. An end beat is answered
// at once, as is a pattern letter that is ignored or whose pattern has failed;
// any other pattern letter reads its slot and then follows or allocates the
// child in a load step. A query walks the trie back through the history, at
// most as many nodes as the history holds, one trie step per cycle through the
// single read port of the node table. A response waiting in the output
// register holds off the next request only until it is taken. The end flag of
// a node is kept beside the child index in the parent's table entry.
module stream_suffix_dictionary_matcher
  import ssdm_pkg::*;
#(
  parameter int NODE_COUNT    = 256,
  parameter int HISTORY_DEPTH = 32,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  output logic req_ready,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_ready
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int UW = $clog2(NODE_COUNT + 1);
  localparam int MD = NODE_COUNT * ALPHABET_SIZE;
  localparam int AW = $clog2(MD);
  localparam int EW = NW + 1;
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [8:0] ALPHA_LIM = 9'(ALPHABET_SIZE);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_WALK} state_t;

  function automatic logic [AW-1:0] slot_addr(logic [NW-1:0] node,
                                              logic [LETTER_W-1:0] code);
    return AW'(node) * AW'(ALPHABET_SIZE) + AW'(code);
  endfunction

  function automatic logic is_bad(logic [LETTER_W-1:0] code);
    return {4'd0, code} >= ALPHA_LIM;
  endfunction

  function automatic logic [HW-1:0] hdec(logic [HW-1:0] p);
    return (p == '0) ? HW'(HISTORY_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [HW-1:0] hinc(logic [HW-1:0] p);
    return (p == HW'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t        state;
  logic [UW-1:0] nodes_used;
  logic [NW-1:0] cursor;
  logic [FW-1:0] load_depth;
  logic [1:0]    load_failed;
  logic [AW-1:0] load_slot;
  logic [HW-1:0] head;
  logic [FW-1:0] fill;
  logic [HW-1:0] hpos;
  logic [FW-1:0] remain;

  logic [LETTER_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [LETTER_W-1:0] hist_q;

  logic          mem_we, mem_re, hist_we, hist_re, clearing;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, node_q;
  logic [HW-1:0] hist_raddr;

  logic          accept, bad, depth_full, table_full, walk_go;
  logic          load_go, rsp_set;
  logic [NW-1:0] rd_child;
  logic          rd_end;
  logic [FW-1:0] fill_next;

  assign req_ready  = (state == ST_IDLE) && !clearing && (!rsp_valid || rsp_ready);
  assign accept     = req_valid && req_ready;
  assign bad        = is_bad(req.letter);
  assign depth_full = load_depth >= FW'(HISTORY_DEPTH);
  assign table_full = nodes_used >= UW'(NODE_COUNT);
  assign rd_child   = node_q[NW-1:0];
  assign rd_end     = node_q[NW];
  assign fill_next  = (fill == FW'(HISTORY_DEPTH)) ? fill : fill + 1'b1;
  assign walk_go    = (rd_child != '0) && !rd_end && (remain != FW'(1)) && !is_bad(hist_q);
  assign load_go    = !bad && (load_failed == STATUS_OK) && !depth_full;

  // every beat answers at once except a trie step or a walk, which answer at their end
  assign rsp_set = (accept && !((req.req_type == REQ_PATTERN) && load_go) &&
                    !((req.req_type == REQ_QUERY) && !bad)) ||
                   (state == ST_LOAD) || ((state == ST_WALK) && !walk_go);

  // memory strobes and addresses
  always_comb begin
    mem_re     = 1'b0;
    mem_raddr  = slot_addr(cursor, req.letter);
    mem_we     = 1'b0;
    mem_waddr  = load_slot;
    mem_wdata  = {1'b0, NW'(nodes_used)};
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    hist_raddr = hdec(head);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            REQ_PATTERN: begin
              mem_re = load_go;
            end
            REQ_END: begin
              mem_we    = (load_failed == STATUS_OK) && (load_depth != '0);
              mem_wdata = {1'b1, cursor};
            end
            REQ_QUERY: begin
              hist_we   = 1'b1;
              mem_raddr = slot_addr('0, req.letter);
              mem_re    = !bad;
              hist_re   = !bad;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        mem_we = (rd_child == '0) && !table_full;
      end
      ST_WALK: begin
        if (walk_go) begin
          mem_re     = 1'b1;
          mem_raddr  = slot_addr(rd_child, hist_q);
          hist_re    = 1'b1;
          hist_raddr = hdec(hpos);
        end
      end
    endcase
  end

  // history ring
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[head] <= req.letter;
    end
    if (hist_re) begin
      hist_q <= hist_mem[hist_raddr];
    end
  end

  // node table; a write always lands before the next beat's first read
  ssdm_node_mem #(
    .DEPTH (MD),
    .DW    (EW)
  ) u_node_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_data  (mem_wdata),
    .rd_en    (mem_re),
    .rd_addr  (mem_raddr),
    .rd_data  (node_q),
    .clearing (clearing)
  );

  // sequencer, loader state and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      nodes_used  <= UW'(1);
      cursor      <= '0;
      load_depth  <= '0;
      load_failed <= STATUS_OK;
      head        <= '0;
      fill        <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      rsp_valid <= rsp_set || (rsp_valid && !rsp_ready);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (req.req_type)
              REQ_PATTERN: begin
                if (bad) begin
                  rsp <= '{match: 1'b0, status: STATUS_OK};
                end else if (load_failed != STATUS_OK) begin
                  rsp <= '{match: 1'b0, status: load_failed};
                end else if (depth_full) begin
                  load_failed <= STATUS_TOO_LONG;
                  rsp         <= '{match: 1'b0, status: STATUS_TOO_LONG};
                end else begin
                  load_slot <= mem_raddr;
                  state     <= ST_LOAD;
                end
              end
              REQ_END: begin
                cursor      <= '0;
                load_depth  <= '0;
                load_failed <= STATUS_OK;
                rsp         <= '{match: 1'b0, status: load_failed};
              end
              REQ_QUERY: begin
                head <= hinc(head);
                fill <= fill_next;
                if (bad) begin
                  rsp <= '{match: 1'b0, status: STATUS_OK};
                end else begin
                  hpos   <= hdec(head);
                  remain <= fill_next;
                  state  <= ST_WALK;
                end
              end
              default: begin
                rsp <= '{match: 1'b0, status: STATUS_OK};
              end
            endcase
          end
        end
        ST_LOAD: begin
          state <= ST_IDLE;
          if ((rd_child == '0) && table_full) begin
            load_failed <= STATUS_FULL;
            rsp         <= '{match: 1'b0, status: STATUS_FULL};
          end else begin
            // existing child, or a freshly allocated node
            if (rd_child == '0) begin
              cursor     <= NW'(nodes_used);
              nodes_used <= nodes_used + 1'b1;
            end else begin
              cursor <= rd_child;
            end
            load_depth <= load_depth + 1'b1;
            rsp        <= '{match: 1'b0, status: STATUS_OK};
          end
        end
        ST_WALK: begin
          if (walk_go) begin
            hpos   <= hdec(hpos);
            remain <= remain - 1'b1;
          end else begin
            state <= ST_IDLE;
            rsp   <= '{match: (rd_child != '0) && rd_end, status: STATUS_OK};
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/ssdm_checker.sv
// ----------------------------------------------------------------------------
// ssdm_checker
// Port-level checks of the suffix dictionary matcher, bound to the top level.
// ----------------------------------------------------------------------------
module ssdm_checker
  import ssdm_pkg::*;
(
  input logic clk,
  input logic rst,
  input req_t req,
  input logic req_valid,
  input logic req_ready,
  input rsp_t rsp,
  input logic rsp_valid,
  input logic rsp_ready
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  // a match beat, which only a query gives, never carries an error status
  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.match |-> rsp.status == STATUS_OK)
    else $error("match beat carries an error status");

  // status stays within its codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == STATUS_OK || rsp.status == STATUS_FULL ||
                   rsp.status == STATUS_TOO_LONG))
    else $error("unknown status code");

  // an end beat answers in the next cycle, without a match
  a_end_reply: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.req_type == REQ_END |=> rsp_valid && !rsp.match)
    else $error("end beat not answered at once");

  // table sweep keeps requests out right after reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request taken during table sweep");

endmodule

bind stream_suffix_dictionary_matcher ssdm_checker u_ssdm_checker (.*);
